FILE: rtl/mpfd_pkg.sv
package mpfd_pkg;

  // field widths of the command and result items
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned DATA_W  = 8;

  // command codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PIXEL = 3'd0,
    ACT_HLINE = 3'd1,
    ACT_VLINE = 3'd2,
    ACT_RECT  = 3'd3,
    ACT_FILL  = 3'd4,
    ACT_CLEAR = 3'd5,
    ACT_READ  = 3'd6
  } action_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG,
    ST_RD,
    ST_WR,
    ST_BYTE,
    ST_BYTE_WAIT,
    ST_DONE
  } state_e;

  // pixel request handed to the pixel unit
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               val;
  } pix_req_t;

endpackage

FILE: rtl/mpfd_ram.sv
module mpfd_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mpfd_pix.sv
module mpfd_pix #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 64,
  parameter int unsigned ADDR_W        = 10
) (
  input  mpfd_pkg::pix_req_t          req_i,
  input  logic [mpfd_pkg::DATA_W-1:0] rdata_i,
  output logic                        ok_o,
  output logic [ADDR_W-1:0]           addr_o,
  output logic [mpfd_pkg::DATA_W-1:0] merged_o
);
  import mpfd_pkg::*;

  logic [COORD_W-4:0] page;
  logic [DATA_W-1:0]  mask;

  // on-panel check
  assign ok_o = ({1'b0, req_i.x} < (COORD_W+1)'(WIDTH_PIXELS)) &&
                ({1'b0, req_i.y} < (COORD_W+1)'(HEIGHT_PIXELS));

  // byte address: column plus page times panel width
  assign page   = req_i.y[COORD_W-1:3];
  assign addr_o = ADDR_W'(req_i.x) + ADDR_W'(page) * ADDR_W'(WIDTH_PIXELS);

  // set or clear the row bit inside the stored byte
  assign mask     = DATA_W'(1) << req_i.y[2:0];
  assign merged_o = req_i.val ? (rdata_i | mask) : (rdata_i & ~mask);

endmodule

FILE: rtl/mono_page_framebuffer_draw_top.sv
// Drawing engine over a page-organized monochrome frame store.
// Command items enter on in_valid_i/in_ready_o with the fields action_i,
// x_coord_i, y_coord_i, x_end_i, y_end_i, run_length_i and pixel_on_i.
// Every command gives exactly one result item on out_valid_o/out_ready_i;
// read_data_o carries the stored byte for a byte read and zero otherwise.
// The block works on one command at a time. Each pixel on the panel is a
// read-modify-write on the single frame memory port pair; a pixel off the
// panel is skipped without a write. Line segments are loaded one by one
// (one per rectangle side, one per filled row), and the result is handed
// off before the next command is accepted. A clear is a one-byte-per-cycle
// memory sweep over all WIDTH_PIXELS*ceil(HEIGHT_PIXELS/8) bytes.
// After reset the block runs the same clearing sweep (over 1024 bytes at the
// default size) with in_ready_o low, then becomes ready.
// Results sit in an output register; while the receiver stalls the next
// command is still accepted and run, and its result waits until the
// output register frees up.
module mono_page_framebuffer_draw_top #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mpfd_pkg::ACT_W-1:0]   action_i,
  input  logic [mpfd_pkg::COORD_W-1:0] x_coord_i,
  input  logic [mpfd_pkg::COORD_W-1:0] y_coord_i,
  input  logic [mpfd_pkg::COORD_W-1:0] x_end_i,
  input  logic [mpfd_pkg::COORD_W-1:0] y_end_i,
  input  logic [mpfd_pkg::COORD_W-1:0] run_length_i,
  input  logic                         pixel_on_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mpfd_pkg::DATA_W-1:0]  read_data_o
);
  import mpfd_pkg::*;

  localparam int unsigned PAGE_COUNT  = (HEIGHT_PIXELS + 7) / 8;
  localparam int unsigned STORE_BYTES = WIDTH_PIXELS * PAGE_COUNT;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  // rectangle outline sides
  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  state_e state_q, state_d;

  // control registers
  logic              out_valid_q, out_valid_d;
  logic              clr_cmd_q, clr_cmd_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  // command and working registers
  action_e            act_q, act_d;
  logic [COORD_W-1:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic [COORD_W-1:0] len_q, len_d, rl_q, rl_d, rh_q, rh_d;
  logic [COORD_W-1:0] seg_q, seg_d, cnt_q, cnt_d;
  logic [COORD_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic               vert_q, vert_d, val_q, val_d, page_ok_q, page_ok_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [DATA_W-1:0]  res_q, res_d, out_data_q, out_data_d;

  // segment setup
  logic [COORD_W-1:0] seg_x, seg_y, seg_cnt;
  logic               seg_vert, last_seg;

  // memory and pixel unit
  pix_req_t          pix_req;
  logic              pix_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [DATA_W-1:0] pix_merged;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign pix_req = '{x: cur_x_q, y: cur_y_q, val: val_q};

  mpfd_pix #(
    .WIDTH_PIXELS (WIDTH_PIXELS),
    .HEIGHT_PIXELS(HEIGHT_PIXELS),
    .ADDR_W       (ADDR_W)
  ) u_pix (
    .req_i   (pix_req),
    .rdata_i (ram_rdata),
    .ok_o    (pix_ok),
    .addr_o  (pix_addr),
    .merged_o(pix_merged)
  );

  mpfd_ram #(
    .DATA_W(DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(pix_addr),
    .rdata_o(ram_rdata)
  );

  // line segment for the current command and segment index
  always_comb begin
    seg_x    = x1_q;
    seg_y    = y1_q;
    seg_cnt  = '0;
    seg_vert = 1'b0;
    last_seg = 1'b1;
    case (act_q)
      ACT_PIXEL: seg_cnt = COORD_W'(1);
      ACT_HLINE: seg_cnt = len_q;
      ACT_VLINE: begin
        seg_cnt  = len_q;
        seg_vert = 1'b1;
      end
      ACT_RECT: begin
        last_seg = (seg_q[1:0] == SIDE_RIGHT);
        case (seg_q[1:0])
          SIDE_TOP: seg_cnt = rl_q;
          SIDE_BOTTOM: begin
            seg_y   = y2_q;
            seg_cnt = rl_q;
          end
          SIDE_LEFT: begin
            seg_cnt  = rh_q;
            seg_vert = 1'b1;
          end
          default: begin
            seg_x    = x2_q;
            seg_cnt  = rh_q;
            seg_vert = 1'b1;
          end
        endcase
      end
      ACT_FILL: begin
        seg_y    = y1_q + seg_q;
        seg_cnt  = rl_q;
        last_seg = (seg_q == rh_q);
      end
      default: ;
    endcase
  end

  // sequencer next state and outputs
  always_comb begin
    state_d     = state_q;
    clr_cmd_d   = clr_cmd_q;
    clr_addr_d  = clr_addr_q;
    act_d       = act_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    len_d       = len_q;
    rl_d        = rl_q;
    rh_d        = rh_q;
    seg_d       = seg_q;
    cnt_d       = cnt_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    vert_d      = vert_q;
    val_d       = val_q;
    page_ok_d   = page_ok_q;
    addr_d      = addr_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = pix_merged;

    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == LAST_ADDR) begin
          state_d = clr_cmd_q ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          act_d     = action_e'(action_i);
          x1_d      = x_coord_i;
          y1_d      = y_coord_i;
          x2_d      = x_end_i;
          y2_d      = y_end_i;
          len_d     = run_length_i;
          rl_d      = x_end_i - x_coord_i + COORD_W'(1);
          rh_d      = y_end_i - y_coord_i;
          val_d     = (action_e'(action_i) == ACT_PIXEL) ? pixel_on_i : 1'b1;
          seg_d     = '0;
          res_d     = '0;
          case (action_e'(action_i))
            ACT_PIXEL, ACT_HLINE, ACT_VLINE, ACT_RECT, ACT_FILL: state_d = ST_SEG;
            ACT_CLEAR: begin
              clr_addr_d = '0;
              clr_cmd_d  = 1'b1;
              state_d    = ST_CLEAR;
            end
            ACT_READ: begin
              cur_x_d   = x_coord_i;
              cur_y_d   = {y_coord_i[4:0], 3'b000};
              page_ok_d = (y_coord_i[COORD_W-1:5] == '0);
              state_d   = ST_BYTE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // load a segment, skip it when empty
      ST_SEG: begin
        cur_x_d = seg_x;
        cur_y_d = seg_y;
        cnt_d   = seg_cnt;
        vert_d  = seg_vert;
        if (seg_cnt != '0) begin
          state_d = ST_RD;
        end else if (last_seg) begin
          state_d = ST_DONE;
        end else begin
          seg_d = seg_q + COORD_W'(1);
        end
      end

      // read and write sides of the read-modify-write, and stepping along the segment
      ST_RD, ST_WR: begin
        if (state_q == ST_RD && pix_ok) begin
          addr_d  = pix_addr;
          state_d = ST_WR;
        end else begin
          ram_we = (state_q == ST_WR);
          if (cnt_q == COORD_W'(1)) begin
            if (last_seg) begin
              state_d = ST_DONE;
            end else begin
              seg_d   = seg_q + COORD_W'(1);
              state_d = ST_SEG;
            end
          end else begin
            cnt_d = cnt_q - COORD_W'(1);
            if (vert_q) begin
              cur_y_d = cur_y_q + COORD_W'(1);
            end else begin
              cur_x_d = cur_x_q + COORD_W'(1);
            end
            state_d = ST_RD;
          end
        end
      end

      // byte read: address goes out in ST_BYTE, data comes back in the cycle after
      ST_BYTE: state_d = ST_BYTE_WAIT;

      ST_BYTE_WAIT: begin
        res_d   = (pix_ok && page_ok_q) ? ram_rdata : '0;
        state_d = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          clr_cmd_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_cmd_q   <= 1'b0;
      clr_addr_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_cmd_q   <= clr_cmd_d;
      clr_addr_q  <= clr_addr_d;
    end
  end

  // command and working data
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    x1_q       <= x1_d;
    y1_q       <= y1_d;
    x2_q       <= x2_d;
    y2_q       <= y2_d;
    len_q      <= len_d;
    rl_q       <= rl_d;
    rh_q       <= rh_d;
    seg_q      <= seg_d;
    cnt_q      <= cnt_d;
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    vert_q     <= vert_d;
    val_q      <= val_d;
    page_ok_q  <= page_ok_d;
    addr_q     <= addr_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule
